>>> rtl/core/button_press_classifier_macros.svh
// Assertion macros for the button press classifier RTL.
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

`ifndef ASSERT_OFF

// Checked property, disabled while the reset is high.
`define BPC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bpc assertion failed");

// Checked property that also holds during reset.
`define BPC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bpc assertion failed");

`else

`define BPC_ASSERT(lbl, clk, rst, prop)
`define BPC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> rtl/core/bpc_pkg.sv
// Shared types and constants of the button press classifier.
package bpc_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned ADDR_W = 5;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [CFG_W-1:0]  ticks_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_REPEAT = 2'd3
  } event_t;

  // Update strobe and the tick time that goes with it.
  typedef struct packed {
    logic  en;
    time_t now;
  } step_t;

endpackage

>>> rtl/core/bpc_tick_if.sv
// Handshake channel that carries one tick sample into the classifier.
interface bpc_tick_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic irq_seen;

  modport source (output valid, output pin_level, output irq_seen, input ready);
  modport sink (input valid, input pin_level, input irq_seen, output ready);
endinterface

>>> rtl/core/bpc_result_if.sv
// Handshake channel that carries one classification result out of the block.
interface bpc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;
  logic       pressed;

  modport source (output valid, output event_code, output pressed, input ready);
  modport sink (input valid, input event_code, input pressed, output ready);
endinterface

>>> rtl/core/bpc_debounce.sv
// Debounce of the pressed level: holds the stable level and the time it was last confirmed.
module bpc_debounce
  import bpc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  step_t  step,
  input  logic   hit,
  input  ticks_t debounce_ticks,
  output logic   stable,
  output logic   stable_upd
);

  logic  stable_next;
  time_t since;
  time_t since_next;
  time_t age;

  assign age = step.now - since;

  always_comb begin
    stable_next = stable;
    since_next  = since;
    if (hit != stable) begin
      if (age > {{(TIME_W-CFG_W){1'b0}}, debounce_ticks}) begin
        stable_next = hit;
        since_next  = step.now;
      end
    end else begin
      since_next = step.now;
    end
  end

  // Level seen by the press machine and the result in this update.
  assign stable_upd = step.en ? stable_next : stable;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable <= 1'b0;
      since  <= '0;
    end else if (step.en) begin
      stable <= stable_next;
      since  <= since_next;
    end
  end

endmodule

>>> rtl/core/bpc_press_fsm.sv
// Idle, pressed, held and repeat machine that classifies debounced presses.
module bpc_press_fsm
  import bpc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  step_t  step,
  input  logic   down,
  input  ticks_t long_press_ticks,
  input  ticks_t repeat_ticks,
  output event_t ev
);

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PRESSED = 2'd1,
    ST_HELD    = 2'd2,
    ST_REPEAT  = 2'd3
  } state_t;

  state_t state;
  state_t state_next;
  time_t  press_start;
  time_t  press_start_next;
  time_t  repeat_last;
  time_t  repeat_last_next;
  time_t  held_for;
  time_t  since_repeat;

  assign held_for     = step.now - press_start;
  assign since_repeat = step.now - repeat_last;

  always_comb begin
    state_next       = state;
    press_start_next = press_start;
    repeat_last_next = repeat_last;
    ev               = EV_NONE;
    case (state)
      ST_IDLE: begin
        if (down) begin
          press_start_next = step.now;
          state_next       = ST_PRESSED;
        end
      end
      ST_PRESSED: begin
        if (!down) begin
          state_next = ST_IDLE;
          ev         = EV_SHORT;
        end else if (held_for >= {{(TIME_W-CFG_W){1'b0}}, long_press_ticks}) begin
          state_next = ST_HELD;
          ev         = EV_LONG;
        end
      end
      ST_HELD: begin
        state_next = down ? ST_REPEAT : ST_IDLE;
      end
      ST_REPEAT: begin
        // The first repeat is timed from the previous repeat, not from entry.
        if (!down) begin
          state_next = ST_IDLE;
        end else if (since_repeat >= {{(TIME_W-CFG_W){1'b0}}, repeat_ticks}) begin
          repeat_last_next = step.now;
          ev               = EV_REPEAT;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (!step.en) begin
      ev = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      press_start <= '0;
      repeat_last <= '0;
    end else if (step.en) begin
      state       <= state_next;
      press_start <= press_start_next;
      repeat_last <= repeat_last_next;
    end
  end

endmodule

>>> rtl/core/button_press_classifier.sv
// Top level of the button press classifier: channels, tick timebase, update gating, registers.
//
// Every transaction on the tick channel stands for one millisecond tick and carries the
// raw pin level and an interrupt bit. For every tick transaction the block returns
// exactly one transaction on the result channel with an event code (none, short press,
// long press, hold repeat) and the debounced pressed state after that tick.
// A 32-bit wrapping tick counter advances once per tick and serves as the time base.
// In polling mode an update runs only when check_interval ticks have passed since the
// previous update; in interrupt mode updates run once an interrupt has been seen, and
// from then on on every tick, since the interrupt flag stays set.
// Timing: a tick is captured in an input register, and all of its work (gating,
// debounce, press machine) is done on its way from there into the result register,
// which offers the result. One tick is taken every cycle while the receiver does not
// stall; the single state update per tick sets that rate.
// When the receiver stalls, the result register holds its transaction and the input
// register holds the next tick, so up to two ticks are in flight before the tick
// channel drops ready. No transaction is lost or repeated.
// Reset (rst, synchronous) empties both registers, clears all time and press state
// and loads the register defaults. Registers are written through the APB port at
// byte address 4*i and are meant to change only while no tick is in flight.
module button_press_classifier
  import bpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  bpc_tick_if.sink          tick,
  bpc_result_if.source      result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

`include "button_press_classifier_macros.svh"

  localparam logic [2:0] REG_ACTIVE_LEVEL = 3'd0;
  localparam logic [2:0] REG_MODE         = 3'd1;
  localparam logic [2:0] REG_DEBOUNCE     = 3'd2;
  localparam logic [2:0] REG_CHECK        = 3'd3;
  localparam logic [2:0] REG_LONG_PRESS   = 3'd4;
  localparam logic [2:0] REG_REPEAT       = 3'd5;

  // Configuration registers.
  logic   cfg_active_level;
  logic   cfg_mode;
  ticks_t cfg_debounce_ticks;
  ticks_t cfg_check_interval;
  ticks_t cfg_long_press_ticks;
  ticks_t cfg_repeat_ticks;
  logic   cfg_write;
  logic [2:0] reg_index;

  // Input register.
  logic s1_valid;
  logic s1_pin;
  logic s1_irq;
  logic adv;

  // Time base and update gating.
  time_t tick_count;
  time_t check_last;
  time_t since_check;
  logic  irq_pending;
  logic  irq_pending_next;
  logic  run;
  step_t step;

  // Submodule results.
  logic   stable;
  logic   stable_upd;
  event_t ev;

  // Result register.
  logic   res_valid;
  event_t res_event;
  logic   res_pressed;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_active_level     <= 1'b0;
      cfg_mode             <= 1'b0;
      cfg_debounce_ticks   <= 16'd20;
      cfg_check_interval   <= 16'd10;
      cfg_long_press_ticks <= 16'd1000;
      cfg_repeat_ticks     <= 16'd200;
    end else if (cfg_write) begin
      case (reg_index)
        REG_ACTIVE_LEVEL: cfg_active_level     <= pwdata[0];
        REG_MODE:         cfg_mode             <= pwdata[0];
        REG_DEBOUNCE:     cfg_debounce_ticks   <= pwdata[CFG_W-1:0];
        REG_CHECK:        cfg_check_interval   <= pwdata[CFG_W-1:0];
        REG_LONG_PRESS:   cfg_long_press_ticks <= pwdata[CFG_W-1:0];
        REG_REPEAT:       cfg_repeat_ticks     <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_ACTIVE_LEVEL: prdata = {31'd0, cfg_active_level};
      REG_MODE:         prdata = {31'd0, cfg_mode};
      REG_DEBOUNCE:     prdata = {16'd0, cfg_debounce_ticks};
      REG_CHECK:        prdata = {16'd0, cfg_check_interval};
      REG_LONG_PRESS:   prdata = {16'd0, cfg_long_press_ticks};
      REG_REPEAT:       prdata = {16'd0, cfg_repeat_ticks};
      default:          prdata = 32'd0;
    endcase
  end

  // ---------------- flow control ----------------
  // The input register moves on whenever the result register is empty or being drained.
  assign adv        = s1_valid && (!res_valid || result.ready);
  assign tick.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_pin <= tick.pin_level;
      s1_irq <= tick.irq_seen;
    end
  end

  // ---------------- update gating ----------------
  // The interrupt flag only arms in interrupt mode and is never cleared afterwards.
  assign irq_pending_next = irq_pending || (s1_irq && cfg_mode);
  assign since_check      = tick_count - check_last;
  assign run = cfg_mode ? irq_pending_next
                        : (since_check >= {{(TIME_W-CFG_W){1'b0}}, cfg_check_interval});

  assign step.en  = adv && run;
  assign step.now = tick_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      check_last  <= '0;
      irq_pending <= 1'b0;
    end else if (adv) begin
      tick_count  <= tick_count + 1'b1;
      irq_pending <= irq_pending_next;
      if (run) begin
        check_last <= tick_count;
      end
    end
  end

  // ---------------- datapath ----------------
  bpc_debounce u_debounce (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .hit            (s1_pin == cfg_active_level),
    .debounce_ticks (cfg_debounce_ticks),
    .stable         (stable),
    .stable_upd     (stable_upd)
  );

  bpc_press_fsm u_press_fsm (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .down             (stable_upd),
    .long_press_ticks (cfg_long_press_ticks),
    .repeat_ticks     (cfg_repeat_ticks),
    .ev               (ev)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_event   <= ev;
      res_pressed <= stable_upd;
    end
  end

  assign result.valid      = res_valid;
  assign result.event_code = res_event;
  assign result.pressed    = res_pressed;

  // ---------------- assertions ----------------
  // Short press is reported on release; long and repeat only while held down.
  `BPC_ASSERT(a_event_vs_level, clk, rst,
    res_valid |-> ((res_event == EV_NONE) || ((res_event == EV_SHORT) == !res_pressed)))
  // The interrupt flag never clears outside reset.
  `BPC_ASSERT(a_irq_sticky, clk, rst, irq_pending |=> irq_pending)
  // The time base moves by exactly one per tick handed to the result register.
  `BPC_ASSERT(a_tick_advance, clk, rst, adv |=> (tick_count == $past(tick_count) + 32'd1))
  // An empty input register always takes a new tick.
  `BPC_ASSERT(a_ready_when_empty, clk, rst, !s1_valid |-> tick.ready)
  // The debounced level only changes on an update.
  `BPC_ASSERT(a_stable_on_update, clk, rst, !step.en |=> $stable(stable))

endmodule

>>> dv/bpc_tb_pkg.sv
// Register map and mode codes shared by the classifier testbench and its checker.
package bpc_tb_pkg;

  localparam int unsigned PADDR_W = 5;

  typedef enum logic [2:0] {
    REG_ACTIVE_LEVEL     = 3'd0,
    REG_MODE             = 3'd1,
    REG_DEBOUNCE_TICKS   = 3'd2,
    REG_CHECK_INTERVAL   = 3'd3,
    REG_LONG_PRESS_TICKS = 3'd4,
    REG_REPEAT_TICKS     = 3'd5,
    REG_UNMAPPED         = 3'd6
  } reg_index_e;

  localparam logic MODE_POLL = 1'b0;
  localparam logic MODE_IRQ  = 1'b1;

endpackage

>>> dv/bpc_checker.sv
// Checker that predicts every classifier result and compares it with the block's output.
module bpc_checker
  import bpc_pkg::*;
  import bpc_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  bpc_tick_if                tick,
  bpc_result_if              result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending
);

  typedef enum logic [1:0] {
    PS_IDLE    = 2'd0,
    PS_PRESSED = 2'd1,
    PS_HELD    = 2'd2,
    PS_REPEAT  = 2'd3
  } press_state_e;

  typedef struct packed {
    event_t code;
    logic   pressed;
  } tick_outcome_t;

  logic         cfg_active_level;
  logic         cfg_mode;
  ticks_t       cfg_debounce;
  ticks_t       cfg_check_interval;
  ticks_t       cfg_long_press;
  ticks_t       cfg_repeat;

  time_t        tick_now;
  time_t        stable_since;
  time_t        press_start;
  time_t        repeat_last;
  time_t        check_last;
  logic         stable_down;
  logic         irq_latched;
  press_state_e press_state;

  tick_outcome_t predicted_outcomes[$];

  // Works out the result of one tick and advances the predicted state.
  function automatic tick_outcome_t classify_tick(logic pin, logic irq);
    tick_outcome_t res;
    time_t         now;
    logic          run;
    logic          hit;
    now = tick_now;
    res.code = EV_NONE;
    if (irq && cfg_mode == MODE_IRQ) irq_latched = 1'b1;
    if (cfg_mode == MODE_IRQ) begin
      run = irq_latched;
    end else begin
      run = time_t'(now - check_last) >= time_t'(cfg_check_interval);
    end
    if (run) begin
      check_last = now;
      hit = (pin == cfg_active_level);
      if (hit != stable_down) begin
        if (time_t'(now - stable_since) > time_t'(cfg_debounce)) begin
          stable_down = hit;
          stable_since = now;
        end
      end else begin
        stable_since = now;
      end
      case (press_state)
        PS_IDLE: begin
          if (stable_down) begin
            press_start = now;
            press_state = PS_PRESSED;
          end
        end
        PS_PRESSED: begin
          if (!stable_down) begin
            press_state = PS_IDLE;
            res.code = EV_SHORT;
          end else if (time_t'(now - press_start) >= time_t'(cfg_long_press)) begin
            press_state = PS_HELD;
            res.code = EV_LONG;
          end
        end
        PS_HELD: begin
          press_state = stable_down ? PS_REPEAT : PS_IDLE;
        end
        default: begin
          // The repeat timer is not restarted on entry, so the first repeat is
          // timed from the previous one.
          if (!stable_down) begin
            press_state = PS_IDLE;
          end else if (time_t'(now - repeat_last) >= time_t'(cfg_repeat)) begin
            repeat_last = now;
            res.code = EV_REPEAT;
          end
        end
      endcase
    end
    tick_now = now + 1;
    res.pressed = stable_down;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    tick_outcome_t want;
    if (rst) begin
      cfg_active_level = 1'b0;
      cfg_mode = MODE_POLL;
      cfg_debounce = 16'd20;
      cfg_check_interval = 16'd10;
      cfg_long_press = 16'd1000;
      cfg_repeat = 16'd200;
      tick_now = '0;
      stable_since = '0;
      press_start = '0;
      repeat_last = '0;
      check_last = '0;
      stable_down = 1'b0;
      irq_latched = 1'b0;
      press_state = PS_IDLE;
      predicted_outcomes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_ACTIVE_LEVEL:     cfg_active_level = pwdata[0];
          REG_MODE:             cfg_mode = pwdata[0];
          REG_DEBOUNCE_TICKS:   cfg_debounce = pwdata[15:0];
          REG_CHECK_INTERVAL:   cfg_check_interval = pwdata[15:0];
          REG_LONG_PRESS_TICKS: cfg_long_press = pwdata[15:0];
          REG_REPEAT_TICKS:     cfg_repeat = pwdata[15:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (predicted_outcomes.size() == 0) begin
          $error("result transaction arrived with no tick outstanding");
          fail_count++;
        end else begin
          want = predicted_outcomes.pop_front();
          if (result.event_code !== want.code) begin
            $error("event_code mismatch: expected %0d, actual %0d",
                   want.code, result.event_code);
            fail_count++;
          end
          if (result.pressed !== want.pressed) begin
            $error("pressed mismatch: expected %0d, actual %0d",
                   want.pressed, result.pressed);
            fail_count++;
          end
        end
      end
      if (tick.valid && tick.ready) begin
        predicted_outcomes.push_back(classify_tick(tick.pin_level, tick.irq_seen));
      end
    end
    pending = predicted_outcomes.size();
  end

endmodule

>>> dv/tb_button_press_classifier.sv
// Top of the button press classifier testbench: clock, reset, stimulus and verdict.
module tb_button_press_classifier;
  import bpc_pkg::*;
  import bpc_tb_pkg::*;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending;

  // When calm is set, neither the tick sender nor the result receiver idles.
  bit calm;
  int stall_left;

  bpc_tick_if   tick_ch();
  bpc_result_if result_ch();

  button_press_classifier DUT (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // The checker sits beside the block, watches every channel and the register
  // port, and reports how many results are still outstanding and how many
  // mismatches it has seen.
  bpc_checker u_press_check (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick_ch),
    .result     (result_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The result receiver stalls now and then in bursts. Each burst starts with ready
  // dropped at a falling edge and stall_left, drawn at random, counting the rest of it.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      result_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // A register write has a setup phase and an access phase. The task is entered
  // and left at a falling edge, so consecutive writes never touch psel twice in
  // the same time step.
  task automatic write_reg(reg_index_e idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes every register. The unused upper data bits carry random garbage,
  // which the block has to drop just as a narrow register would.
  task automatic configure(logic act, logic md, ticks_t deb, ticks_t chk,
                           ticks_t lng, ticks_t rpt);
    write_reg(REG_ACTIVE_LEVEL, {31'($urandom), act});
    write_reg(REG_MODE, {31'($urandom), md});
    write_reg(REG_DEBOUNCE_TICKS, {16'($urandom), deb});
    write_reg(REG_CHECK_INTERVAL, {16'($urandom), chk});
    write_reg(REG_LONG_PRESS_TICKS, {16'($urandom), lng});
    write_reg(REG_REPEAT_TICKS, {16'($urandom), rpt});
  endtask

  // Offers one tick transaction, entered at a falling edge. Outside the calm
  // stretch the sender sometimes idles for a random gap first. The task
  // returns at the falling edge after the transaction was taken, with valid
  // still high so that back-to-back ticks never lower and raise it in one step.
  task automatic send_tick(logic pin, logic irq);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 10);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.pin_level <= pin;
    tick_ch.irq_seen <= irq;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_run(logic pin, logic irq, int count);
    repeat (count) send_tick(pin, irq);
  endtask

  // Stops the tick stream and waits until every predicted result has come back,
  // which leaves the block idle. Every tick yields a result, so nothing can
  // still be in flight once the checker has nothing outstanding.
  task automatic drain();
    tick_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic   act;
    logic   md;
    logic   down;
    logic   pin;
    logic   irq;
    bit     noisy;
    int     seg_len;
    int     sent;
    ticks_t deb;
    ticks_t chk;
    ticks_t lng;
    ticks_t rpt;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tick_ch.valid = 1'b0;
    tick_ch.pin_level = 1'b0;
    tick_ch.irq_seen = 1'b0;
    result_ch.ready = 1'b1;
    calm = 1'b0;
    stall_left = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed part. With no debounce and no rate limit every tick is an update,
    // so a press of two ticks gives a short press, and a long hold gives a long
    // press, one tick in the held state and then a repeat on every update. The
    // interrupt bit sent in polling mode must be ignored.
    configure(1'b1, MODE_POLL, 16'd0, 16'd0, 16'd3, 16'd1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_run(1'b0, 1'b0, 2);
    send_run(1'b1, 1'b0, 7);
    send_run(1'b0, 1'b0, 2);
    drain();

    // Rate limit: only every other tick may update, the rest report no event
    // and the unchanged pressed state.
    write_reg(REG_CHECK_INTERVAL, 32'd2);
    send_run(1'b1, 1'b0, 2);
    send_run(1'b0, 1'b0, 2);
    drain();

    // A write to an index past the register map must change nothing.
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);

    // Interrupt mode: nothing updates until the first interrupt, after which
    // the flag stays set and every later tick updates, interrupt or not.
    write_reg(REG_MODE, {31'd0, MODE_IRQ});
    send_run(1'b1, 1'b0, 2);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    drain();

    // Random part, in phases with a fresh setting each. The first phases take
    // the extremes of every register; the rest use small values so that
    // debounce, long presses and repeats happen often within a phase. The last
    // two phases run with no idling on either side.
    for (int phase = 0; phase < 10; phase++) begin
      calm = (phase >= 8);
      case (phase)
        0: begin
          act = 1'b0; md = MODE_POLL;
          deb = 16'hFFFF; chk = 16'hFFFF; lng = 16'hFFFF; rpt = 16'hFFFF;
        end
        1: begin
          act = 1'b1; md = MODE_IRQ;
          deb = 16'd0; chk = 16'd0; lng = 16'd0; rpt = 16'd0;
        end
        2: begin
          act = 1'b0; md = MODE_POLL;
          deb = 16'd0; chk = 16'd0; lng = 16'd0; rpt = 16'd0;
        end
        3: begin
          act = 1'b1; md = MODE_POLL;
          deb = 16'd2; chk = 16'hFFFF; lng = 16'd4; rpt = 16'd2;
        end
        default: begin
          act = 1'($urandom_range(0, 1));
          md = 1'($urandom_range(0, 1));
          deb = ticks_t'($urandom_range(0, 4));
          chk = ticks_t'($urandom_range(0, 3));
          lng = ticks_t'($urandom_range(0, 24));
          rpt = ticks_t'($urandom_range(0, 8));
        end
      endcase
      configure(act, md, deb, chk, lng, rpt);

      // Most segments are clean presses and releases of random length, with a
      // bounce now and then at the start; a few are pure noise on the pin.
      down = 1'b0;
      sent = 0;
      while (sent < 103) begin
        seg_len = $urandom_range(1, 30);
        noisy = ($urandom_range(0, 6) == 0);
        for (int i = 0; i < seg_len; i++) begin
          if (noisy) begin
            pin = 1'($urandom);
          end else begin
            pin = down ? act : !act;
            if (i < 2 && $urandom_range(0, 3) == 0) pin = !pin;
          end
          irq = ($urandom_range(0, 4) == 0);
          send_tick(pin, irq);
        end
        down = !down;
        sent += seg_len;
      end
      drain();
    end

    // Let any stray result show up before the verdict.
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_button_press_classifier passed");
    end else begin
      $display("tb_button_press_classifier failed");
    end
    $finish;
  end

  // Guard against a hang, for example a result that never arrives.
  initial begin
    #200000;
    $display("tb_button_press_classifier failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/bpc_pkg.sv
rtl/core/bpc_tick_if.sv
rtl/core/bpc_result_if.sv
rtl/core/bpc_debounce.sv
rtl/core/bpc_press_fsm.sv
rtl/core/button_press_classifier.sv
dv/bpc_tb_pkg.sv
dv/bpc_checker.sv
dv/tb_button_press_classifier.sv
